@@ hdl/ssad_pkg.sv @@
// ---------------------------------------------------------------------------
// SAD stereo matcher package
// Shared widths, register indexes and the job record passed from the pixel
// front end to the matching engine.
// ---------------------------------------------------------------------------
`default_nettype none

package ssad_pkg;

    localparam int PIX_W      = 8;
    localparam int ROW_W      = 10;
    localparam int COL_W      = 12;
    localparam int SLOT_W     = 5;
    localparam int K_W        = 8;
    localparam int WS_W       = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int MAX_HEIGHT = 1024;

    localparam logic [CFG_IDX_W-1:0] REG_IMG_W = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMG_H = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DISP  = 2'd3;

    typedef struct packed {
        logic [PIX_W-1:0]  left;
        logic [PIX_W-1:0]  right;
        logic [COL_W-1:0]  col;
        logic [SLOT_W-1:0] slot;
        logic              match;
        logic [ROW_W-1:0]  arow;
        logic [COL_W-1:0]  acol;
        logic [SLOT_W-1:0] aslot;
        logic [K_W-1:0]    kmax;
        logic [WS_W-1:0]   ws;
    } t_job;

endpackage

`default_nettype wire

@@ hdl/ssad_front.sv @@
// ---------------------------------------------------------------------------
// SAD stereo front end
// Holds the configuration, tracks the raster position and classifies each
// pixel pair into a store-only or a store-and-match job.
// ---------------------------------------------------------------------------
`default_nettype none

module ssad_front import ssad_pkg::*; #(
    parameter int MAX_WIDTH     = 1024,
    parameter int MAX_WINDOW    = 15,
    parameter int MAX_DISPARITY = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wen,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                  i_acc,
    input  wire logic [PIX_W-1:0]      i_left,
    input  wire logic [PIX_W-1:0]      i_right,
    input  wire logic                  i_frame_start,
    output t_job                       o_job
);

    logic [10:0]       r_img_w, r_img_h;
    logic [3:0]        r_win;
    logic [6:0]        r_disp;
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;
    logic [SLOT_W-1:0] r_slot;

    logic [12:0]       w_c, c0, c1, c2, ac, dr_m1;
    logic [11:0]       h_c, r0, r1, r2, ar;
    logic [SLOT_W-1:0] ws_c, wsm1, s0, s1, s2;
    logic [8:0]        dr_c;
    logic [5:0]        aslot;
    logic              match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= 11'd384;
            r_img_h <= 11'd288;
            r_win   <= 4'd7;
            r_disp  <= 7'd30;
        end else if (i_cfg_wen) begin
            case (i_cfg_idx)
                REG_IMG_W: r_img_w <= i_cfg_wdata;
                REG_IMG_H: r_img_h <= i_cfg_wdata;
                REG_WIN:   r_win   <= i_cfg_wdata[3:0];
                REG_DISP:  r_disp  <= i_cfg_wdata[6:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        w_c = (r_img_w == '0) ? 13'd1 :
              ((13'(r_img_w) > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : 13'(r_img_w));
        h_c = (r_img_h == '0) ? 12'd1 :
              ((12'(r_img_h) > 12'(MAX_HEIGHT)) ? 12'(MAX_HEIGHT) : 12'(r_img_h));
        ws_c = (r_win == '0) ? 5'd1 :
               ((5'(r_win) > 5'(MAX_WINDOW)) ? 5'(MAX_WINDOW) : 5'(r_win));
        dr_c = (r_disp == '0) ? 9'd1 :
               ((9'(r_disp) > 9'(MAX_DISPARITY)) ? 9'(MAX_DISPARITY) : 9'(r_disp));
        wsm1 = ws_c - 5'd1;

        // position of this pixel, folding in a shrunken frame size
        c0 = i_frame_start ? 13'd0 : 13'(r_col);
        r0 = i_frame_start ? 12'd0 : 12'(r_row);
        s0 = i_frame_start ? '0 : r_slot;
        c1 = c0;
        r1 = r0;
        s1 = s0;
        if (c0 >= w_c) begin
            c1 = '0;
            r1 = r0 + 12'd1;
            s1 = (s0 == SLOT_W'(MAX_WINDOW - 1)) ? '0 : s0 + 5'd1;
        end
        if (r1 >= h_c) begin
            r1 = '0;
            s1 = '0;
        end

        ar = r1 + 12'd1 - 12'(ws_c);
        ac = c1 + 13'd1 - 13'(ws_c);
        match = (r1 + 12'd1 >= 12'(ws_c)) && (c1 + 13'd1 >= 13'(ws_c)) &&
                (ac + 13'(ws_c) < w_c) && (ar + 12'(ws_c) < h_c);
        dr_m1 = 13'(dr_c) - 13'd1;
        aslot = (s1 >= wsm1) ? 6'(s1 - wsm1) : 6'(s1) + 6'(MAX_WINDOW) - 6'(wsm1);

        // advance
        c2 = c1 + 13'd1;
        r2 = r1;
        s2 = s1;
        if (c2 >= w_c) begin
            c2 = '0;
            r2 = r1 + 12'd1;
            s2 = (s1 == SLOT_W'(MAX_WINDOW - 1)) ? '0 : s1 + 5'd1;
            if (r2 >= h_c) begin
                r2 = '0;
                s2 = '0;
            end
        end

        o_job.left  = i_left;
        o_job.right = i_right;
        o_job.col   = c1[COL_W-1:0];
        o_job.slot  = s1;
        o_job.match = match;
        o_job.arow  = ar[ROW_W-1:0];
        o_job.acol  = ac[COL_W-1:0];
        o_job.aslot = aslot[SLOT_W-1:0];
        o_job.kmax  = (dr_m1 > ac) ? ac[K_W-1:0] : dr_m1[K_W-1:0];
        o_job.ws    = ws_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_slot <= '0;
        end else if (i_acc) begin
            r_row  <= r2[ROW_W-1:0];
            r_col  <= c2[COL_W-1:0];
            r_slot <= s2;
        end
    end

endmodule

`default_nettype wire

@@ hdl/ssad_queue.sv @@
// ---------------------------------------------------------------------------
// SAD stereo job queue
// Two-entry queue of jobs between the front end and the matching engine.
// ---------------------------------------------------------------------------
`default_nettype none

module ssad_queue import ssad_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_job      i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_job      o_job
);

    t_job       r_mem [0:1];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

`default_nettype wire

@@ hdl/ssad_back.sv @@
// ---------------------------------------------------------------------------
// SAD stereo matching engine
// Writes each pixel pair into the line stores and, for a matching job, scores
// every candidate shift one pixel pair per cycle and keeps the first minimum.
// ---------------------------------------------------------------------------
`default_nettype none

module ssad_back import ssad_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_WINDOW = 15
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_qvalid,
    input  t_job       i_job,
    output logic       o_pop,
    output logic       o_valid,
    input  wire logic  i_ready,
    output logic [31:0] o_data
);

    localparam int DEPTH = MAX_WINDOW * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int SUMW  = $clog2(MAX_WINDOW * MAX_WINDOW * 255 + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [PIX_W-1:0] r_mem_l [0:DEPTH-1];
    logic [PIX_W-1:0] r_mem_r [0:DEPTH-1];

    logic [1:0]        r_state, n_state;
    t_job              r_job;
    logic [K_W-1:0]    r_k, r_k1;
    logic [WS_W-1:0]   r_y, r_x;
    logic [SLOT_W-1:0] r_ys;
    logic              r_v1, r_last1;
    logic [PIX_W-1:0]  r_rd_l, r_rd_r;
    logic [SUMW-1:0]   r_acc, r_best;
    logic [K_W-1:0]    r_bk;
    logic              r_ov;
    logic [31:0]       r_od;

    logic [AW-1:0]     wr_addr, rd_addr_l, rd_addr_r, row_base;
    logic [COL_W-1:0]  col_l, col_r;
    logic              wen, x_end, y_end, issue_last, load_out;
    logic [PIX_W-1:0]  diff;
    logic [SUMW-1:0]   tot;

    assign o_pop    = (r_state == S_IDLE) && i_qvalid;
    assign wen      = o_pop;
    assign wr_addr  = AW'(AW'(i_job.slot) * AW'(MAX_WIDTH) + AW'(i_job.col));
    assign row_base = AW'(AW'(r_ys) * AW'(MAX_WIDTH));
    assign col_l    = r_job.acol + COL_W'(r_x);
    assign col_r    = r_job.acol - COL_W'(r_k) + COL_W'(r_x);
    assign rd_addr_l = row_base + AW'(col_l);
    assign rd_addr_r = row_base + AW'(col_r);
    assign x_end    = (r_x == r_job.ws - 5'd1);
    assign y_end    = (r_y == r_job.ws - 5'd1);
    assign issue_last = x_end && y_end && (r_k == r_job.kmax);
    assign load_out = (r_state == S_OUT) && (!r_ov || i_ready);
    assign diff     = (r_rd_l > r_rd_r) ? r_rd_l - r_rd_r : r_rd_r - r_rd_l;
    assign tot      = r_acc + SUMW'(diff);

    always_ff @(posedge i_clk) begin
        if (wen) begin
            r_mem_l[wr_addr] <= i_job.left;
            r_mem_r[wr_addr] <= i_job.right;
        end
        r_rd_l <= r_mem_l[rd_addr_l];
        r_rd_r <= r_mem_r[rd_addr_r];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_qvalid && i_job.match) n_state = S_RUN;
            S_RUN:   if (issue_last) n_state = S_FIN;
            S_FIN:   n_state = S_OUT;
            S_OUT:   if (load_out) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_v1    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= (r_state == S_RUN);
            if (load_out)
                r_ov <= 1'b1;
            else if (i_ready)
                r_ov <= 1'b0;
        end
    end

    // window walk: x fastest, then rows, then shifts
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
            r_k   <= '0;
            r_y   <= '0;
            r_x   <= '0;
            r_ys  <= i_job.aslot;
            r_acc <= '0;
        end else if (r_state == S_RUN) begin
            if (x_end) begin
                r_x <= '0;
                if (y_end) begin
                    r_y  <= '0;
                    r_ys <= r_job.aslot;
                    r_k  <= r_k + K_W'(1);
                end else begin
                    r_y  <= r_y + 5'd1;
                    r_ys <= (r_ys == SLOT_W'(MAX_WINDOW - 1)) ? '0 : r_ys + 5'd1;
                end
            end else begin
                r_x <= r_x + 5'd1;
            end
        end
        r_last1 <= x_end && y_end;
        r_k1    <= r_k;
        if (r_v1) begin
            if (r_last1) begin
                r_acc <= '0;
                if (r_k1 == '0 || tot < r_best) begin
                    r_best <= tot;
                    r_bk   <= r_k1;
                end
            end else begin
                r_acc <= tot;
            end
        end
        if (load_out)
            r_od <= {6'd0, r_job.acol[9:0], r_job.arow, r_bk[5:0]};
    end

    assign o_valid = r_ov;
    assign o_data  = r_od;

    a_fin_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |=> (r_state == S_OUT))
        else $error("finish state not followed by output state");

    a_run_has_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> r_job.match)
        else $error("scoring a job without a match");

    a_k_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_k <= r_job.kmax))
        else $error("shift beyond the searched range");

endmodule

`default_nettype wire

@@ hdl/stereo_sad_disparity_core.sv @@
// Flow: a request that completes a window is scored through the run, finish and output
// states once the engine is idle; any other request only writes the line stores.
// Throughput: one pixel pair per cycle to the line stores while the engine is idle, one
// window pixel pair per cycle when scoring, set by the single read port of each line store.
// Reset: synchronous, active low; clears position, queue and output valid and
// loads the default registers. Line stores are not cleared.
// ---------------------------------------------------------------------------
// SAD stereo disparity core
// Block matching over a stereo pixel stream with a two-entry job queue.
// ---------------------------------------------------------------------------
`default_nettype none

module stereo_sad_disparity_core import ssad_pkg::*; #(
    parameter int MAX_WIDTH     = 1024,
    parameter int MAX_WINDOW    = 15,
    parameter int MAX_DISPARITY = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wen,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [15:0]           s_axis_tdata,  // left_pixel, right_pixel
    input  wire logic                  s_axis_tuser,  // frame_start
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [31:0]                m_axis_tdata   // disparity, anchor_row, anchor_col
);

    t_job f_job, q_job;
    logic q_full, q_valid, pop, acc;

    assign s_axis_tready = !q_full;
    assign acc = s_axis_tvalid && s_axis_tready;

    ssad_front #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_WINDOW    (MAX_WINDOW),
        .MAX_DISPARITY (MAX_DISPARITY)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_acc         (acc),
        .i_left        (s_axis_tdata[7:0]),
        .i_right       (s_axis_tdata[15:8]),
        .i_frame_start (s_axis_tuser),
        .o_job         (f_job)
    );

    ssad_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (acc),
        .i_job   (f_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    ssad_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_qvalid (q_valid),
        .i_job    (q_job),
        .o_pop    (pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_data   (m_axis_tdata)
    );

endmodule

`default_nettype wire
